// ===== src/bse_pkg.sv =====
// Shared types, command and status codes for the bounded stack engine.
package bse_pkg;

    // Default stack depth in words.
    localparam int DEPTH_DEFAULT = 8;

    // Number of items the command queue between front and back holds.
    localparam int QDEPTH = 2;

    // Command codes as they arrive on the input channel.
    localparam logic [2:0] CMD_PUSH      = 3'd0;
    localparam logic [2:0] CMD_POP       = 3'd1;
    localparam logic [2:0] CMD_DISPLAY   = 3'd2;
    localparam logic [2:0] CMD_PEEK_TOP  = 3'd3;
    localparam logic [2:0] CMD_PEEK_BOT  = 3'd4;
    localparam logic [2:0] CMD_POP_N     = 3'd5;

    // Result status codes.
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_OVERFLOW   = 3'd1;
    localparam logic [2:0] ST_UNDERFLOW  = 3'd2;
    localparam logic [2:0] ST_TOOFEW     = 3'd3;
    localparam logic [2:0] ST_EMPTY      = 3'd4;

    // Entry of the peek from the bottom of the stack.
    localparam int PEEK_BOT_INDEX = 2;

    // One classified command as it waits in the queue.
    typedef struct packed {
        logic [2:0]          kind;
        logic signed [31:0]  word;
        logic [3:0]          count;
    } cmd_item_t;

    // Queue status seen by the front and back parts.
    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

// ===== src/bse_front.sv =====
// Front part: unpacks and classifies incoming command items.
module bse_front (
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [39:0]         s_tdata,  // command[2:0], push_value[34:3], pop_count[38:35]
    input  bse_pkg::q_stat_t    q_stat,
    output logic                q_push,
    output bse_pkg::cmd_item_t  q_item
);
    import bse_pkg::*;

    logic [2:0] command;
    logic       known_cmd;

    // Field unpacking.
    assign command      = s_tdata[2:0];
    assign q_item.kind  = command;
    assign q_item.word  = s_tdata[34:3];
    assign q_item.count = s_tdata[38:35];

    // Unused command codes are accepted and dropped here; they cause no result.
    always_comb begin
        case (command)
            CMD_PUSH, CMD_POP, CMD_DISPLAY,
            CMD_PEEK_TOP, CMD_PEEK_BOT, CMD_POP_N: known_cmd = 1'b1;
            default:                               known_cmd = 1'b0;
        endcase
    end

    assign s_tready = !q_stat.full;
    assign q_push   = s_tvalid && s_tready && known_cmd;

endmodule

// ===== src/bse_queue.sv =====
// Short command queue between the front and back parts.
module bse_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  bse_pkg::cmd_item_t  push_item,
    input  logic                pop,
    output bse_pkg::cmd_item_t  head_item,
    output bse_pkg::q_stat_t    stat
);
    import bse_pkg::*;

    localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW = $clog2(QDEPTH + 1);

    cmd_item_t        entry_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   count_reg, count_next;
    logic             do_push, do_pop;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == QCW'(QDEPTH));
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_item  = entry_reg[rd_ptr_reg];

    // Pointer and fill-count update, wrapping at the queue depth.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QAW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QAW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + QCW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue payload needs no reset.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== src/bse_back.sv =====
// Back part: executes queued commands on the stack memory and drives results.
module bse_back #(
    parameter int DEPTH = bse_pkg::DEPTH_DEFAULT,
    parameter int OW    = $clog2(DEPTH + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  bse_pkg::cmd_item_t  head_item,
    input  bse_pkg::q_stat_t    q_stat,
    output logic                q_pop,
    output logic                busy,
    output logic [OW-1:0]       occupancy,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,  // value[31:0]
    output logic [2:0]          m_tuser,  // status[2:0]
    output logic                m_tlast
);
    import bse_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = (OW > 4) ? OW : 4;

    // Stack memory, one write and one registered read port.
    logic signed [31:0] stack_mem [DEPTH];

    logic [OW-1:0]      occ_reg, occ_next;
    logic [OW-1:0]      remain_reg, remain_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic               busy_reg, busy_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] out_value_reg;
    logic [2:0]         out_status_reg;
    logic               out_last_reg;

    logic               adv;
    logic               out_load;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] const_value;
    logic [2:0]         status_n;
    logic               last_n;
    logic [CW-1:0]      occ_ext, cnt_ext;
    logic [AW-1:0]      top_addr, below_top_addr, third_addr;

    assign adv            = !out_valid_reg || m_tready;
    assign occ_ext        = CW'(occ_reg);
    assign cnt_ext        = CW'(head_item.count);
    assign top_addr       = AW'(occ_reg - OW'(1));
    assign below_top_addr = AW'(occ_reg - OW'(2));
    assign third_addr     = AW'(occ_reg - OW'(3));
    assign wr_addr        = occ_reg[AW-1:0];

    // Command sequencer: one result per cycle whenever the output slot is free.
    always_comb begin
        occ_next       = occ_reg;
        remain_next    = remain_reg;
        addr_next      = addr_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_load       = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = addr_reg;
        wr_en          = 1'b0;
        const_value    = '0;
        status_n       = ST_OK;
        last_n         = 1'b1;
        q_pop          = 1'b0;

        if (busy_reg) begin
            // Streaming the remaining words of a display or pop-n.
            if (adv) begin
                out_load    = 1'b1;
                rd_en       = 1'b1;
                last_n      = (remain_reg == OW'(1));
                remain_next = remain_reg - OW'(1);
                addr_next   = addr_reg - AW'(1);
                busy_next   = (remain_reg != OW'(1));
            end
        end else if (!q_stat.empty && adv) begin
            q_pop    = 1'b1;
            out_load = 1'b1;
            case (head_item.kind)
                CMD_PUSH: begin
                    if (occ_reg == OW'(DEPTH)) begin
                        status_n = ST_OVERFLOW;
                    end else begin
                        wr_en    = 1'b1;
                        occ_next = occ_reg + OW'(1);
                    end
                end
                CMD_POP: begin
                    if (occ_reg == '0) begin
                        status_n    = ST_UNDERFLOW;
                        const_value = '1;
                    end else begin
                        rd_en    = 1'b1;
                        rd_addr  = top_addr;
                        occ_next = occ_reg - OW'(1);
                    end
                end
                CMD_DISPLAY: begin
                    if (occ_reg == '0) begin
                        status_n = ST_EMPTY;
                    end else begin
                        rd_en       = 1'b1;
                        rd_addr     = top_addr;
                        last_n      = (occ_reg == OW'(1));
                        remain_next = occ_reg - OW'(1);
                        addr_next   = below_top_addr;
                        busy_next   = (occ_reg != OW'(1));
                    end
                end
                CMD_PEEK_TOP: begin
                    if (occ_reg < OW'(3)) begin
                        status_n = ST_TOOFEW;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = third_addr;
                    end
                end
                CMD_PEEK_BOT: begin
                    if (occ_reg < OW'(3)) begin
                        status_n = ST_TOOFEW;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(PEEK_BOT_INDEX);
                    end
                end
                CMD_POP_N: begin
                    if (cnt_ext == '0) begin
                        status_n = ST_OK;
                    end else if (cnt_ext > occ_ext) begin
                        status_n = ST_TOOFEW;
                    end else begin
                        rd_en       = 1'b1;
                        rd_addr     = top_addr;
                        last_n      = (cnt_ext == CW'(1));
                        occ_next    = OW'(occ_ext - cnt_ext);
                        remain_next = OW'(cnt_ext - CW'(1));
                        addr_next   = below_top_addr;
                        busy_next   = (cnt_ext != CW'(1));
                    end
                end
                default: begin
                    out_load = 1'b0;
                end
            endcase
        end

        if (out_load) begin
            out_valid_next = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg       <= '0;
            remain_reg    <= '0;
            addr_reg      <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            occ_reg       <= occ_next;
            remain_reg    <= remain_next;
            addr_reg      <= addr_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stack memory write and registered read straight into the output register.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[wr_addr] <= head_item.word;
        end
        if (out_load) begin
            if (rd_en) begin
                out_value_reg <= stack_mem[rd_addr];
            end else begin
                out_value_reg <= const_value;
            end
            out_status_reg <= status_n;
            out_last_reg   <= last_n;
        end
    end

    assign busy      = busy_reg;
    assign occupancy = occ_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_value_reg;
    assign m_tuser   = out_status_reg;
    assign m_tlast   = out_last_reg;

endmodule

// ===== src/bounded_stack_engine.sv =====
// Top level of the bounded stack engine: front, command queue and back part.
//
//  Channel  Direction  Payload
//  s_       in         tdata: command[2:0], push_value[34:3], pop_count[38:35]
//  m_       out        tdata: value[31:0]; tuser: status[2:0]; tlast: last
//
// Push, pop and both peeks each give one result word. Display and pop-n give one
// word per cycle while the output is not stalled, limited by the single read port
// of the stack memory. Reset clears only the occupancy and the control state; the
// stack words are undefined until pushed. A two-item queue lets the input side
// take up to two more items while the output side stalls.
module bounded_stack_engine #(
    parameter int DEPTH = bse_pkg::DEPTH_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,  // command[2:0], push_value[34:3], pop_count[38:35]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,  // value[31:0]
    output logic [2:0]   m_tuser,  // status[2:0]
    output logic         m_tlast
);
    import bse_pkg::*;

    localparam int OW = $clog2(DEPTH + 1);

    cmd_item_t     push_item;
    cmd_item_t     head_item;
    q_stat_t       q_stat;
    logic          q_push;
    logic          q_pop;
    logic          busy;
    logic [OW-1:0] occupancy;

    bse_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    bse_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head_item (head_item),
        .stat      (q_stat)
    );

    bse_back #(
        .DEPTH (DEPTH),
        .OW    (OW)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_item (head_item),
        .q_stat    (q_stat),
        .q_pop     (q_pop),
        .busy      (busy),
        .occupancy (occupancy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

`ifndef SYNTHESIS
    // The stack never holds more words than its depth.
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occupancy <= OW'(DEPTH))
        else $error("stack occupancy exceeds depth");

    // No new command is taken from the queue while a multi-word answer streams.
    a_no_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !q_pop)
        else $error("queue popped while streaming");

    // Any status other than ok ends the answer to its command.
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_OK) |-> m_tlast)
        else $error("error result without last");

    // Once streaming ends, the final streamed item carries last.
    a_stream_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(busy) |-> (m_tvalid && m_tlast))
        else $error("stream ended without last item");
`endif

endmodule

// ===== verif/bounded_stack_engine_tb.sv =====
// Self-checking testbench for the bounded stack engine, with its own stack predictor.
module bounded_stack_engine_tb;
    import bse_pkg::*;

    localparam int STACK_DEPTH   = DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS  = 380;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_REPORTS   = 10;

    // Codes the block ignores.
    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;

    // One command for the input channel, or a marker that waits for all results.
    typedef struct {
        logic [2:0]         cmd;
        logic signed [31:0] word;
        logic [3:0]         count;
        bit                 pause;
    } stack_cmd_t;

    // One result as the output channel carries it.
    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0]         status;
        logic               last;
    } stack_result_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    stack_cmd_t    pending_cmds[$];
    stack_result_t owed_results[$];

    // Predictor state: a private copy of the stack.
    logic signed [31:0] shadow_stack [STACK_DEPTH];
    int                 shadow_occ    = 0;

    int  mismatches   = 0;
    int  items_taken  = 0;
    bit  nothing_owed = 1'b1;
    bit  sender_calm  = 1'b0;
    bit  sender_pause = 1'b0;
    int  cycles       = 0;
    int  gen_occ      = 0;

    bounded_stack_engine u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // command[2:0], push_value[34:3], pop_count[38:35]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // value[31:0]
        .m_tuser  (m_tuser),   // status[2:0]
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Idle length: mostly short, now and then long.
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 80) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 30);
    endfunction

    task automatic owe(input logic signed [31:0] value, input logic [2:0] status,
                       input logic last);
        stack_result_t r;
        r.value  = value;
        r.status = status;
        r.last   = last;
        owed_results.push_back(r);
    endtask

    // Works out the results of one accepted command and updates the shadow stack.
    task automatic stack_predict(input stack_cmd_t c);
        int i;
        case (c.cmd)
            CMD_PUSH: begin
                if (shadow_occ >= STACK_DEPTH) begin
                    owe(32'sd0, ST_OVERFLOW, 1'b1);
                end else begin
                    shadow_stack[shadow_occ] = c.word;
                    shadow_occ++;
                    owe(32'sd0, ST_OK, 1'b1);
                end
            end
            CMD_POP: begin
                if (shadow_occ == 0) begin
                    owe(-32'sd1, ST_UNDERFLOW, 1'b1);
                end else begin
                    shadow_occ--;
                    owe(shadow_stack[shadow_occ], ST_OK, 1'b1);
                end
            end
            CMD_DISPLAY: begin
                if (shadow_occ == 0) begin
                    owe(32'sd0, ST_EMPTY, 1'b1);
                end else begin
                    for (i = 0; i < shadow_occ; i++) begin
                        owe(shadow_stack[shadow_occ - 1 - i], ST_OK, i == shadow_occ - 1);
                    end
                end
            end
            CMD_PEEK_TOP: begin
                if (shadow_occ < 3) owe(32'sd0, ST_TOOFEW, 1'b1);
                else owe(shadow_stack[shadow_occ - 3], ST_OK, 1'b1);
            end
            CMD_PEEK_BOT: begin
                if (shadow_occ < 3) owe(32'sd0, ST_TOOFEW, 1'b1);
                else owe(shadow_stack[PEEK_BOT_INDEX], ST_OK, 1'b1);
            end
            CMD_POP_N: begin
                if (c.count == 0) begin
                    owe(32'sd0, ST_OK, 1'b1);
                end else if (c.count > shadow_occ) begin
                    owe(32'sd0, ST_TOOFEW, 1'b1);
                end else begin
                    for (i = 0; i < c.count; i++) begin
                        shadow_occ--;
                        owe(shadow_stack[shadow_occ], ST_OK, i == c.count - 1);
                    end
                end
            end
            default: begin
                // Spare codes give nothing and leave the stack alone.
            end
        endcase
    endtask

    // Queues a command and follows its effect on the depth the generator assumes.
    task automatic add_cmd(input logic [2:0] cmd, input logic signed [31:0] word,
                           input logic [3:0] count);
        stack_cmd_t c;
        c.cmd   = cmd;
        c.word  = word;
        c.count = count;
        c.pause = 1'b0;
        pending_cmds.push_back(c);
        if (cmd == CMD_PUSH && gen_occ < STACK_DEPTH) gen_occ++;
        else if (cmd == CMD_POP && gen_occ > 0) gen_occ--;
        else if (cmd == CMD_POP_N && count != 0 && count <= gen_occ) gen_occ -= count;
    endtask

    task automatic add_pause();
        stack_cmd_t c;
        c.cmd   = CMD_PUSH;
        c.word  = '0;
        c.count = '0;
        c.pause = 1'b1;
        pending_cmds.push_back(c);
    endtask

    // Sender: presents queued items, with random gaps and the odd full pause.
    always @(posedge aclk) begin
        stack_cmd_t nxt;
        int         gap_left;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end else if (!s_tvalid || s_tready) begin
            if (sender_pause) begin
                s_tvalid <= 1'b0;
                if (nothing_owed) sender_pause = 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                nxt = pending_cmds.pop_front();
                if (nxt.pause) begin
                    sender_pause = 1'b1;
                    s_tvalid <= 1'b0;
                end else begin
                    s_tdata  <= {1'b0, nxt.count, nxt.word, nxt.cmd};
                    s_tvalid <= 1'b1;
                    if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
                    if (!sender_calm && $urandom_range(0, 2) == 0) gap_left = pick_gap();
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus two long hold-offs that fill the block up.
    always @(posedge aclk) begin
        int stall_left;
        int hold_left;
        int holds_done;
        bit calm;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
            holds_done = 0;
            calm       = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (holds_done < 2 && items_taken >= 150 + 200 * holds_done) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 49) == 0) calm = !calm;
            if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    // Monitor: predicts on each accepted command, then checks each accepted result.
    always @(posedge aclk) begin
        stack_cmd_t    c;
        stack_result_t want;
        stack_result_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                c.cmd   = s_tdata[2:0];
                c.word  = s_tdata[34:3];
                c.count = s_tdata[38:35];
                c.pause = 1'b0;
                stack_predict(c);
                items_taken <= items_taken + 1;
            end
            if (m_tvalid && m_tready) begin
                got.value  = m_tdata;
                got.status = m_tuser;
                got.last   = m_tlast;
                if (owed_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("Unexpected result: value %0d status %0d last %0b",
                                 got.value, got.status, got.last);
                end else begin
                    want = owed_results.pop_front();
                    if (got.value !== want.value || got.status !== want.status ||
                        got.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("Result mismatch: value %0d/%0d status %0d/%0d %s %0b/%0b",
                                     want.value, got.value, want.status, got.status,
                                     "last", want.last, got.last);
                    end
                end
            end
            nothing_owed <= (owed_results.size() == 0);
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial begin
        int n;
        int r;
        int k;
        logic [3:0] cnt;

        // Directed: empty-stack cases, value extremes, full stack and spare codes.
        add_cmd(CMD_POP, 32'sd0, 4'd0);
        add_cmd(CMD_DISPLAY, 32'sd0, 4'd0);
        add_cmd(CMD_PEEK_TOP, 32'sd0, 4'd0);
        add_cmd(CMD_PEEK_BOT, 32'sd0, 4'd0);
        add_cmd(CMD_POP_N, 32'sd0, 4'd0);
        add_cmd(CMD_POP_N, 32'sd0, 4'd1);
        add_cmd(CMD_PUSH, 32'h8000_0000, 4'd0);
        add_cmd(CMD_PUSH, 32'h7FFF_FFFF, 4'd0);
        add_cmd(CMD_PEEK_BOT, 32'sd0, 4'd0);
        add_cmd(CMD_PUSH, -32'sd1, 4'd0);
        add_cmd(CMD_PEEK_TOP, 32'sd0, 4'd0);
        add_cmd(CMD_PEEK_BOT, 32'sd0, 4'd0);
        for (k = 0; k < 5; k++) add_cmd(CMD_PUSH, $urandom, 4'd0);
        add_cmd(CMD_PUSH, 32'sd0, 4'd0);
        add_cmd(CMD_DISPLAY, 32'sd0, 4'd0);
        add_cmd(CMD_POP_N, 32'sd0, 4'd15);
        add_cmd(CMD_POP_N, 32'sd0, 4'd8);
        add_cmd(CMD_SPARE_A, $urandom, 4'($urandom));
        add_cmd(CMD_SPARE_B, $urandom, 4'($urandom));
        add_cmd(CMD_POP, 32'sd0, 4'd0);
        add_pause();

        // Random: pushes dominate while the stack is shallow so that deep states are reached.
        n = 0;
        while (n < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                add_cmd(($urandom_range(0, 1) == 1) ? CMD_SPARE_A : CMD_SPARE_B,
                        $urandom, 4'($urandom));
                continue;
            end
            if (r < ((gen_occ < 3) ? 60 : 35)) begin
                add_cmd(CMD_PUSH, $urandom, 4'($urandom));
            end else begin
                r = $urandom_range(0, 99);
                if (r < 25) begin
                    add_cmd(CMD_POP, $urandom, 4'($urandom));
                end else if (r < 42) begin
                    add_cmd(CMD_DISPLAY, $urandom, 4'($urandom));
                end else if (r < 58) begin
                    add_cmd(CMD_PEEK_TOP, $urandom, 4'($urandom));
                end else if (r < 74) begin
                    add_cmd(CMD_PEEK_BOT, $urandom, 4'($urandom));
                end else begin
                    if ($urandom_range(0, 9) == 0) cnt = 4'($urandom_range(0, 15));
                    else cnt = 4'($urandom_range(0, gen_occ));
                    add_cmd(CMD_POP_N, $urandom, cnt);
                end
            end
            n++;
            if (n % 100 == 0) add_pause();
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for the last item to go in and every result to come back.
        @(negedge aclk);
        while (pending_cmds.size() > 0 || s_tvalid || sender_pause || !nothing_owed)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatches == 0 && owed_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== bounded_stack_engine.f =====
src/bse_pkg.sv
src/bse_front.sv
src/bse_queue.sv
src/bse_back.sv
src/bounded_stack_engine.sv
verif/bounded_stack_engine_tb.sv
